// ===== rtl/arc_pkg.sv =====
// ----------------------------------------------------------------------------
// arc_pkg
// Types and constants shared by the ARP cache resolver modules.
// ----------------------------------------------------------------------------
package arc_pkg;

  typedef enum logic [1:0] {
    KIND_PACKET  = 2'd0,
    KIND_RESOLVE = 2'd1,
    KIND_TICK    = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE,
    ST_DONE
  } ctrl_state_e;

  localparam logic [2:0] STATUS_DONE       = 3'd0;
  localparam logic [2:0] STATUS_SHORT      = 3'd1;
  localparam logic [2:0] STATUS_BAD_HW     = 3'd2;
  localparam logic [2:0] STATUS_BAD_PROTO  = 3'd3;
  localparam logic [2:0] STATUS_FOUND      = 3'd4;
  localparam logic [2:0] STATUS_INCOMPLETE = 3'd5;

  localparam logic [1:0] SEND_NONE    = 2'd0;
  localparam logic [1:0] SEND_REQUEST = 2'd1;
  localparam logic [1:0] SEND_REPLY   = 2'd2;

  localparam logic [1:0] ES_FREE       = 2'd0;
  localparam logic [1:0] ES_INCOMPLETE = 2'd1;
  localparam logic [1:0] ES_RESOLVED   = 2'd2;
  localparam logic [1:0] ES_STATIC     = 2'd3;

  localparam logic [1:0] CFG_OWN_IP        = 2'd0;
  localparam logic [1:0] CFG_OWN_MAC       = 2'd1;
  localparam logic [1:0] CFG_IP_CONFIGURED = 2'd2;
  localparam logic [1:0] CFG_TIMEOUT       = 2'd3;

  localparam logic [10:0] MIN_FRAME_LEN  = 11'd28;
  localparam logic [15:0] HW_ETHERNET    = 16'h0001;
  localparam logic [15:0] PROTO_IPV4     = 16'h0800;
  localparam logic [7:0]  HW_ADDR_LEN    = 8'd6;
  localparam logic [7:0]  PROTO_ADDR_LEN = 8'd4;
  localparam logic [15:0] OP_REQUEST     = 16'h0001;
  localparam logic [7:0]  TIMEOUT_RESET  = 8'd30;

  typedef struct packed {
    logic [1:0]  state;
    logic [31:0] ip;
    logic [47:0] mac;
    logic [15:0] stamp;
  } entry_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [1:0]  send_kind;
    logic [31:0] send_target_ip;
    logic [47:0] send_target_mac;
    logic [47:0] resolved_mac;
  } result_t;

  // Summary of one pass over the table.
  typedef struct packed {
    logic        hit;
    logic [1:0]  hit_state;
    logic [47:0] hit_mac;
    logic        free_found;
  } scan_info_t;

endpackage

// ===== rtl/arc_if.sv =====
// ----------------------------------------------------------------------------
// arc_if
// Valid/ready channels for request words and result words.
// ----------------------------------------------------------------------------
interface arc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [10:0] frame_length;
  logic [15:0] hw_type;
  logic [15:0] proto_type;
  logic [7:0]  hw_addr_len;
  logic [7:0]  proto_addr_len;
  logic [15:0] opcode;
  logic [47:0] sender_mac;
  logic [31:0] sender_ip;
  logic [31:0] target_ip;
  logic [31:0] resolve_ip;

  modport source (output valid, kind, frame_length, hw_type, proto_type, hw_addr_len,
                  proto_addr_len, opcode, sender_mac, sender_ip, target_ip, resolve_ip,
                  input ready);
  modport sink (input valid, kind, frame_length, hw_type, proto_type, hw_addr_len,
                proto_addr_len, opcode, sender_mac, sender_ip, target_ip, resolve_ip,
                output ready);
endinterface

interface arc_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [1:0]  send_kind;
  logic [31:0] send_target_ip;
  logic [47:0] send_target_mac;
  logic [47:0] resolved_mac;

  modport source (output valid, status, send_kind, send_target_ip, send_target_mac,
                  resolved_mac, input ready);
  modport sink (input valid, status, send_kind, send_target_ip, send_target_mac,
                resolved_mac, output ready);
endinterface

// ===== rtl/arc_entry_mem.sv =====
// ----------------------------------------------------------------------------
// arc_entry_mem
// Cache table: one synchronous memory plus a valid flop per entry.
// ----------------------------------------------------------------------------
module arc_entry_mem
  import arc_pkg::*;
#(
  parameter int ENTRIES = 32,
  parameter int IDX_W   = 5
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             rd_en_i,
  input  logic [IDX_W-1:0] rd_addr_i,
  output entry_t           rd_data_o,
  output logic             rd_valid_o,
  input  logic             wr_en_i,
  input  logic [IDX_W-1:0] wr_addr_i,
  input  entry_t           wr_data_i,
  input  logic             clr_en_i,
  input  logic [IDX_W-1:0] clr_addr_i
);

  entry_t             mem [ENTRIES];
  logic [ENTRIES-1:0] vld_q;
  entry_t             rd_data_q;
  logic               rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  // A freed or never written entry reads as all zero through its valid bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (clr_en_i) begin
        vld_q[clr_addr_i] <= 1'b0;
      end
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
    end
  end

  assign rd_valid_o = rd_vld_q;
  assign rd_data_o  = rd_vld_q ? rd_data_q : '0;

endmodule

// ===== rtl/arc_scan.sv =====
// ----------------------------------------------------------------------------
// arc_scan
// Walks the read data of a table pass: lookup, free slot, oldest slot, expiry.
// ----------------------------------------------------------------------------
module arc_scan
  import arc_pkg::*;
#(
  parameter int IDX_W = 5
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic             dv_i,
  input  logic [IDX_W-1:0] didx_i,
  input  logic             evld_i,
  input  entry_t           entry_i,
  input  logic [31:0]      key_i,
  input  logic [15:0]      now_i,
  input  logic [7:0]       timeout_i,
  input  logic             tick_i,
  output logic             expire_o,
  output scan_info_t       info_o,
  output logic [IDX_W-1:0] hit_idx_o,
  output logic [IDX_W-1:0] slot_idx_o
);

  scan_info_t       info_q, info_d;
  logic [IDX_W-1:0] hit_idx_q, hit_idx_d;
  logic [IDX_W-1:0] free_idx_q, free_idx_d;
  logic [IDX_W-1:0] old_idx_q, old_idx_d;
  logic [15:0]      old_age_q, old_age_d;
  logic [15:0]      age;

  assign age = now_i - entry_i.stamp;

  always_comb begin
    info_d     = info_q;
    hit_idx_d  = hit_idx_q;
    free_idx_d = free_idx_q;
    old_idx_d  = old_idx_q;
    old_age_d  = old_age_q;
    if (start_i) begin
      info_d = '0;
    end else if (dv_i) begin
      if (evld_i) begin
        if (!info_q.hit && entry_i.ip == key_i) begin
          info_d.hit       = 1'b1;
          info_d.hit_state = entry_i.state;
          info_d.hit_mac   = entry_i.mac;
          hit_idx_d        = didx_i;
        end
        // The first entry seeds the search; later ones replace only when strictly older.
        if (didx_i == '0 || age > old_age_q) begin
          old_idx_d = didx_i;
          old_age_d = age;
        end
      end else if (!info_q.free_found) begin
        info_d.free_found = 1'b1;
        free_idx_d        = didx_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      info_q <= '0;
    end else begin
      info_q <= info_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_idx_q  <= hit_idx_d;
    free_idx_q <= free_idx_d;
    old_idx_q  <= old_idx_d;
    old_age_q  <= old_age_d;
  end

  assign expire_o = dv_i && tick_i && evld_i &&
                    (entry_i.state == ES_INCOMPLETE || entry_i.state == ES_RESOLVED) &&
                    (age > {8'd0, timeout_i});

  assign info_o     = info_q;
  assign hit_idx_o  = hit_idx_q;
  assign slot_idx_o = info_q.free_found ? free_idx_q : old_idx_q;

endmodule

// ===== rtl/arp_cache_resolver.sv =====
// ----------------------------------------------------------------------------
// arp_cache_resolver
// ARP offload cache with oldest-entry eviction and timed aging.
// ----------------------------------------------------------------------------
// Each accepted word is handled alone. A packet that fails the length or type
// checks, or a word of unknown kind, goes straight to the done state with no
// table pass. Every other word makes one pass over the table memory, one entry
// per cycle through its single read port, then an update step; the next word
// is taken once the result sits in the output register. A tick frees expired
// entries during its pass; lookups, learning and eviction write at most one
// entry after the pass.
module arp_cache_resolver
  import arc_pkg::*;
#(
  parameter int ENTRIES = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [47:0] cfg_data_i,
  arc_in_if.sink      in_i,
  arc_out_if.source   out_o
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);

  // Configuration registers.
  logic [31:0] own_ip_q;
  logic [47:0] own_mac_q;
  logic        ip_cfg_q;
  logic [7:0]  timeout_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_ip_q  <= '0;
      own_mac_q <= '0;
      ip_cfg_q  <= 1'b0;
      timeout_q <= TIMEOUT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_OWN_IP:        own_ip_q  <= cfg_data_i[31:0];
        CFG_OWN_MAC:       own_mac_q <= cfg_data_i;
        CFG_IP_CONFIGURED: ip_cfg_q  <= cfg_data_i[0];
        CFG_TIMEOUT:       timeout_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  ctrl_state_e      state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             dv_q;
  logic [IDX_W-1:0] didx_q;
  logic [15:0]      now_q, now_d;
  logic             out_valid_q, out_valid_d;
  result_t          res_q, res_d;
  result_t          out_q;

  // Captured word.
  logic [1:0]  kind_q;
  logic [15:0] op_q;
  logic [47:0] smac_q;
  logic [31:0] sip_q;
  logic [31:0] tip_q;
  logic [31:0] rip_q;

  logic       accept;
  logic       pkt_ok;
  logic [2:0] pkt_status;
  logic       rd_en;
  logic       last_data;
  logic       out_free;

  entry_t           rd_data;
  logic             rd_valid;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  entry_t           wr_data;
  logic             expire;
  scan_info_t       info;
  logic [IDX_W-1:0] hit_idx;
  logic [IDX_W-1:0] slot_idx;
  logic [31:0]      key;
  logic             for_us;

  assign accept   = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;

  always_comb begin
    pkt_status = STATUS_DONE;
    if (in_i.frame_length < MIN_FRAME_LEN) begin
      pkt_status = STATUS_SHORT;
    end else if (in_i.hw_type != HW_ETHERNET || in_i.hw_addr_len != HW_ADDR_LEN) begin
      pkt_status = STATUS_BAD_HW;
    end else if (in_i.proto_type != PROTO_IPV4 || in_i.proto_addr_len != PROTO_ADDR_LEN) begin
      pkt_status = STATUS_BAD_PROTO;
    end
  end
  assign pkt_ok = (pkt_status == STATUS_DONE);

  assign rd_en     = (state_q == ST_SCAN) && (cnt_q < CNT_W'(ENTRIES));
  assign last_data = dv_q && (didx_q == IDX_W'(ENTRIES - 1));
  assign key       = (kind_q == KIND_RESOLVE) ? rip_q : sip_q;
  assign for_us    = ip_cfg_q && (own_ip_q == tip_q);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if ((in_i.kind == KIND_PACKET && pkt_ok) || in_i.kind == KIND_RESOLVE ||
              in_i.kind == KIND_TICK) begin
            state_d = ST_SCAN;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_SCAN: begin
        if (last_data) begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: state_d = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs and datapath.
  always_comb begin
    cnt_d       = cnt_q;
    now_d       = now_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && !out_o.ready;
    wr_en       = 1'b0;
    wr_addr     = slot_idx;
    wr_data     = '0;
    wr_data.stamp = now_q;
    case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
        if (accept) begin
          res_d = '0;
          if (in_i.kind == KIND_PACKET) begin
            res_d.status = pkt_status;
          end
          if (in_i.kind == KIND_TICK) begin
            now_d = now_q + 16'd1;
          end
        end
      end
      ST_SCAN: begin
        if (rd_en) begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      ST_UPDATE: begin
        case (kind_q)
          KIND_PACKET: begin
            wr_data.state = ES_RESOLVED;
            wr_data.ip    = sip_q;
            wr_data.mac   = smac_q;
            if (info.hit) begin
              wr_en   = 1'b1;
              wr_addr = hit_idx;
            end else if (for_us) begin
              wr_en = 1'b1;
            end
            if (for_us && op_q == OP_REQUEST) begin
              res_d.send_kind       = SEND_REPLY;
              res_d.send_target_ip  = sip_q;
              res_d.send_target_mac = smac_q;
            end
          end
          KIND_RESOLVE: begin
            wr_data.state = ES_INCOMPLETE;
            wr_data.ip    = rip_q;
            if (!info.hit || info.hit_state == ES_INCOMPLETE) begin
              wr_en                = !info.hit;
              res_d.status         = STATUS_INCOMPLETE;
              res_d.send_kind      = SEND_REQUEST;
              res_d.send_target_ip = rip_q;
            end else begin
              res_d.status       = STATUS_FOUND;
              res_d.resolved_mac = info.hit_mac;
            end
          end
          default: ;
        endcase
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      dv_q        <= 1'b0;
      now_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      dv_q        <= rd_en;
      now_q       <= now_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q  <= res_d;
    didx_q <= cnt_q[IDX_W-1:0];
    if (accept) begin
      kind_q <= in_i.kind;
      op_q   <= in_i.opcode;
      smac_q <= in_i.sender_mac;
      sip_q  <= in_i.sender_ip;
      tip_q  <= in_i.target_ip;
      rip_q  <= in_i.resolve_ip;
    end
    if (state_q == ST_DONE && out_free) begin
      out_q <= res_q;
    end
  end

  arc_entry_mem #(
    .ENTRIES(ENTRIES),
    .IDX_W  (IDX_W)
  ) u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_addr_i (cnt_q[IDX_W-1:0]),
    .rd_data_o (rd_data),
    .rd_valid_o(rd_valid),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .clr_en_i  (expire),
    .clr_addr_i(didx_q)
  );

  arc_scan #(
    .IDX_W(IDX_W)
  ) u_scan (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (accept),
    .dv_i      (dv_q),
    .didx_i    (didx_q),
    .evld_i    (rd_valid),
    .entry_i   (rd_data),
    .key_i     (key),
    .now_i     (now_q),
    .timeout_i (timeout_q),
    .tick_i    (kind_q == KIND_TICK),
    .expire_o  (expire),
    .info_o    (info),
    .hit_idx_o (hit_idx),
    .slot_idx_o(slot_idx)
  );

  assign in_i.ready            = (state_q == ST_IDLE);
  assign out_o.valid           = out_valid_q;
  assign out_o.status          = out_q.status;
  assign out_o.send_kind       = out_q.send_kind;
  assign out_o.send_target_ip  = out_q.send_target_ip;
  assign out_o.send_target_mac = out_q.send_target_mac;
  assign out_o.resolved_mac    = out_q.resolved_mac;

`ifndef SYNTH
  // A word taken in always leaves the idle state on the next cycle.
  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q != ST_IDLE)
    else $error("accepted word did not start processing");

  // The table is written only after a full pass, never while it is read.
  a_write_after_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> state_q == ST_UPDATE && !dv_q && !rd_en)
    else $error("table write overlaps a pass");

  // Read data only returns during a pass.
  a_data_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_q |-> state_q == ST_SCAN)
    else $error("read data outside a pass");

  // Expiry only happens for a tick.
  a_expire_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    expire |-> kind_q == KIND_TICK && state_q == ST_SCAN)
    else $error("entry freed outside a tick pass");
`endif

endmodule

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the ARP cache resolver. A driver feeds packet, resolve, tick
// and unknown-kind words from a queue; a monitor compares every result word with the
// output of a behavioral cache model kept in the testbench.
// ----------------------------------------------------------------------------
module tb_top;
  import arc_pkg::*;

  localparam int N_ENTRIES = 32;
  localparam int CYCLE_LIMIT = 600000;

  typedef struct packed {
    logic [1:0]  kind;
    logic [10:0] frame_length;
    logic [15:0] hw_type;
    logic [15:0] proto_type;
    logic [7:0]  hw_addr_len;
    logic [7:0]  proto_addr_len;
    logic [15:0] opcode;
    logic [47:0] sender_mac;
    logic [31:0] sender_ip;
    logic [31:0] target_ip;
    logic [31:0] resolve_ip;
  } arp_word_t;

  localparam int WORD_W = $bits(arp_word_t);

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [47:0] cfg_data_i = '0;

  arc_in_if  req_if ();
  arc_out_if res_if ();

  arp_cache_resolver #(.ENTRIES(N_ENTRIES)) dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_i(req_if.sink), .out_o(res_if.source)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Cache model state and its copy of the registers.
  logic [1:0]  c_state [N_ENTRIES];
  logic [31:0] c_ip    [N_ENTRIES];
  logic [47:0] c_mac   [N_ENTRIES];
  logic [15:0] c_stamp [N_ENTRIES];
  logic [15:0] c_now;
  logic [31:0] m_own_ip;
  logic [47:0] m_own_mac;
  logic        m_ip_cfg;
  logic [7:0]  m_timeout;

  arp_word_t pending_words[$];
  result_t   expected_results[$];
  int  send_idle_pct = 0, recv_idle_pct = 0;
  bit  recv_hold = 0;
  int  hold_cycles = 0;
  int  errors = 0;
  int  cycles = 0;
  logic [31:0] ip_pool[8];

  function automatic int lookup_ip(logic [31:0] ip);
    for (int i = 0; i < N_ENTRIES; i++)
      if (c_state[i] != ES_FREE && c_ip[i] == ip) return i;
    return -1;
  endfunction

  function automatic int victim_slot();
    int best;
    logic [15:0] best_age, age;
    best = 0;
    best_age = '0;
    for (int i = 0; i < N_ENTRIES; i++) begin
      if (c_state[i] == ES_FREE) return i;
      age = c_now - c_stamp[i];
      if (i == 0 || age > best_age) begin
        best = i;
        best_age = age;
      end
    end
    return best;
  endfunction

  function automatic result_t resolve_word(arp_word_t w);
    result_t r;
    int i;
    bit merged;
    logic [15:0] age;
    r = '0;
    if (w.kind == KIND_PACKET) begin
      if (w.frame_length < MIN_FRAME_LEN) r.status = STATUS_SHORT;
      else if (w.hw_type != HW_ETHERNET || w.hw_addr_len != HW_ADDR_LEN)
        r.status = STATUS_BAD_HW;
      else if (w.proto_type != PROTO_IPV4 || w.proto_addr_len != PROTO_ADDR_LEN)
        r.status = STATUS_BAD_PROTO;
      else begin
        merged = 0;
        i = lookup_ip(w.sender_ip);
        if (i >= 0) begin
          c_state[i] = ES_RESOLVED;
          c_mac[i] = w.sender_mac;
          c_stamp[i] = c_now;
          merged = 1;
        end
        if (m_ip_cfg && m_own_ip == w.target_ip) begin
          if (!merged) begin
            i = victim_slot();
            c_state[i] = ES_RESOLVED;
            c_ip[i] = w.sender_ip;
            c_mac[i] = w.sender_mac;
            c_stamp[i] = c_now;
          end
          if (w.opcode == OP_REQUEST) begin
            r.send_kind = SEND_REPLY;
            r.send_target_ip = w.sender_ip;
            r.send_target_mac = w.sender_mac;
          end
        end
      end
    end else if (w.kind == KIND_RESOLVE) begin
      i = lookup_ip(w.resolve_ip);
      if (i < 0) begin
        i = victim_slot();
        c_state[i] = ES_INCOMPLETE;
        c_ip[i] = w.resolve_ip;
        c_mac[i] = '0;
        c_stamp[i] = c_now;
      end
      if (c_state[i] == ES_INCOMPLETE) begin
        r.status = STATUS_INCOMPLETE;
        r.send_kind = SEND_REQUEST;
        r.send_target_ip = w.resolve_ip;
      end else begin
        r.status = STATUS_FOUND;
        r.resolved_mac = c_mac[i];
      end
    end else if (w.kind == KIND_TICK) begin
      c_now = c_now + 16'd1;
      for (int k = 0; k < N_ENTRIES; k++)
        if (c_state[k] == ES_INCOMPLETE || c_state[k] == ES_RESOLVED) begin
          age = c_now - c_stamp[k];
          if (age > m_timeout) begin
            c_state[k] = ES_FREE;
            c_ip[k] = '0;
            c_mac[k] = '0;
            c_stamp[k] = '0;
          end
        end
    end
    return r;
  endfunction

  // Driver: the predictor runs when a word is accepted.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
    end else begin
      if (req_if.valid && req_if.ready)
        expected_results.push_back(resolve_word(arp_word_t'({req_if.kind,
          req_if.frame_length, req_if.hw_type, req_if.proto_type,
          req_if.hw_addr_len, req_if.proto_addr_len, req_if.opcode,
          req_if.sender_mac, req_if.sender_ip, req_if.target_ip,
          req_if.resolve_ip})));
      if ((!req_if.valid || req_if.ready) && pending_words.size() > 0 &&
          $urandom_range(99) >= send_idle_pct) begin
        arp_word_t w;
        w = pending_words.pop_front();
        req_if.valid <= 1'b1;
        {req_if.kind, req_if.frame_length, req_if.hw_type, req_if.proto_type,
         req_if.hw_addr_len, req_if.proto_addr_len, req_if.opcode,
         req_if.sender_mac, req_if.sender_ip, req_if.target_ip,
         req_if.resolve_ip} <= w;
      end else if (req_if.ready) begin
        req_if.valid <= 1'b0;
      end
    end
  end

  initial begin
    {req_if.kind, req_if.frame_length, req_if.hw_type, req_if.proto_type,
     req_if.hw_addr_len, req_if.proto_addr_len, req_if.opcode, req_if.sender_mac,
     req_if.sender_ip, req_if.target_ip, req_if.resolve_ip} = '0;
    req_if.valid = 1'b0;
    res_if.ready = 1'b0;
  end

  // Monitor and receiver stall control.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else begin
      cycles <= cycles + 1;
      if (res_if.valid && res_if.ready) begin
        if (expected_results.size() == 0) begin
          $error("result word with no expectation");
          errors = errors + 1;
        end else begin
          result_t e;
          e = expected_results.pop_front();
          if (res_if.status !== e.status) begin
            $error("status exp %0d got %0d", e.status, res_if.status);
            errors = errors + 1;
          end
          if (res_if.send_kind !== e.send_kind) begin
            $error("send_kind exp %0d got %0d", e.send_kind, res_if.send_kind);
            errors = errors + 1;
          end
          if (res_if.send_target_ip !== e.send_target_ip) begin
            $error("send_target_ip exp %h got %h", e.send_target_ip,
                   res_if.send_target_ip);
            errors = errors + 1;
          end
          if (res_if.send_target_mac !== e.send_target_mac) begin
            $error("send_target_mac exp %h got %h", e.send_target_mac,
                   res_if.send_target_mac);
            errors = errors + 1;
          end
          if (res_if.resolved_mac !== e.resolved_mac) begin
            $error("resolved_mac exp %h got %h", e.resolved_mac,
                   res_if.resolved_mac);
            errors = errors + 1;
          end
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        res_if.ready <= 1'b0;
      end else if (recv_hold) begin
        hold_cycles <= 400;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
      if (cycles > CYCLE_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  function automatic arp_word_t good_packet();
    arp_word_t w;
    w = '0;
    w.kind = KIND_PACKET;
    w.frame_length = MIN_FRAME_LEN + 11'($urandom_range(40));
    w.hw_type = HW_ETHERNET;
    w.proto_type = PROTO_IPV4;
    w.hw_addr_len = HW_ADDR_LEN;
    w.proto_addr_len = PROTO_ADDR_LEN;
    w.opcode = ($urandom_range(3) != 0) ? OP_REQUEST : 16'($urandom_range(4));
    w.sender_mac = 48'({$urandom(), $urandom()});
    w.sender_ip = ip_pool[$urandom_range(7)];
    w.target_ip = ($urandom_range(3) != 0) ? m_own_ip : $urandom();
    w.resolve_ip = $urandom();
    return w;
  endfunction

  function automatic arp_word_t random_word();
    arp_word_t w;
    int pick;
    pick = $urandom_range(99);
    if (pick < 45) w = good_packet();
    else if (pick < 75) begin
      w = WORD_W'({$urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                   $urandom(), $urandom(), $urandom(), $urandom()});
      w.kind = KIND_RESOLVE;
      w.resolve_ip = ($urandom_range(3) != 0) ? ip_pool[$urandom_range(7)] : $urandom();
    end else if (pick < 88) begin
      w = good_packet();
      w.kind = KIND_TICK;
    end else if (pick < 97) begin
      w = good_packet();
      case ($urandom_range(2))
        0: w.frame_length = 11'($urandom_range(2047));
        1: begin
          w.hw_type = 16'($urandom());
          w.hw_addr_len = 8'($urandom());
        end
        default: begin
          w.proto_type = 16'($urandom());
          w.proto_addr_len = 8'($urandom());
        end
      endcase
    end else begin
      w = WORD_W'({$urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                   $urandom(), $urandom(), $urandom(), $urandom()});
      w.kind = 2'd3;
    end
    return w;
  endfunction

  task automatic drain();
    while (pending_words.size() > 0 || req_if.valid || expected_results.size() > 0)
      @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [47:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_OWN_IP:        m_own_ip = val[31:0];
      CFG_OWN_MAC:       m_own_mac = val;
      CFG_IP_CONFIGURED: m_ip_cfg = val[0];
      default:           m_timeout = val[7:0];
    endcase
  endtask

  initial begin
    arp_word_t w;
    for (int i = 0; i < N_ENTRIES; i++) begin
      c_state[i] = ES_FREE;
      c_ip[i] = '0;
      c_mac[i] = '0;
      c_stamp[i] = '0;
    end
    c_now = '0;
    m_own_ip = '0;
    m_own_mac = '0;
    m_ip_cfg = 1'b0;
    m_timeout = TIMEOUT_RESET;
    for (int i = 0; i < 8; i++) ip_pool[i] = $urandom();
    ip_pool[0] = '0;
    ip_pool[1] = '1;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Unconfigured interface: nothing targets us, resolves are still served.
    pending_words.push_back(good_packet());
    w = '0;
    w.kind = KIND_RESOLVE;
    w.resolve_ip = '1;
    pending_words.push_back(w);
    pending_words.push_back(w);
    drain();

    write_reg(CFG_OWN_IP, 48'hFFFF_FFFF_FFFF);
    write_reg(CFG_OWN_MAC, 48'hFFFF_FFFF_FFFF);
    write_reg(CFG_IP_CONFIGURED, 48'd1);
    write_reg(CFG_TIMEOUT, 48'd0);

    // Directed: each rejection reason, replies, unknown kind, fast expiry.
    w = good_packet();
    w.frame_length = 11'd27;
    pending_words.push_back(w);
    w.frame_length = 11'h7FF;
    w.hw_type = 16'hFFFF;
    pending_words.push_back(w);
    w.hw_type = HW_ETHERNET;
    w.hw_addr_len = 8'hFF;
    pending_words.push_back(w);
    w.hw_addr_len = HW_ADDR_LEN;
    w.proto_type = 16'h0;
    pending_words.push_back(w);
    w.proto_type = PROTO_IPV4;
    w.proto_addr_len = 8'd0;
    pending_words.push_back(w);
    w.proto_addr_len = PROTO_ADDR_LEN;
    w.target_ip = m_own_ip;
    w.opcode = OP_REQUEST;
    w.sender_mac = '1;
    pending_words.push_back(w);
    w.opcode = 16'hFFFF;
    w.sender_mac = '0;
    pending_words.push_back(w);
    w.kind = KIND_RESOLVE;
    w.resolve_ip = w.sender_ip;
    pending_words.push_back(w);
    w.kind = 2'd3;
    pending_words.push_back(w);
    w.kind = KIND_TICK;
    pending_words.push_back(w);
    pending_words.push_back(w);
    w.kind = KIND_RESOLVE;
    pending_words.push_back(w);
    drain();

    // Learn entries from packets with distinct sender addresses; every fifth word is a tick.
    write_reg(CFG_OWN_IP, 48'h0);
    write_reg(CFG_TIMEOUT, 48'd255);
    for (int i = 0; i < 40; i++) begin
      w = good_packet();
      w.sender_ip = 32'h0A00_0000 + i;
      if (i % 5 == 0) begin
        w.kind = KIND_TICK;
      end
      pending_words.push_back(w);
    end
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 10 : (ph == 1) ? 66 : 0;
      recv_idle_pct = (ph == 0) ? 66 : (ph == 1) ? 10 : 0;
      write_reg(CFG_OWN_IP, {16'h0, ip_pool[$urandom_range(7)]});
      write_reg(CFG_OWN_MAC, 48'({$urandom(), $urandom()}));
      write_reg(CFG_IP_CONFIGURED, 48'($urandom_range(1)));
      write_reg(CFG_TIMEOUT, (ph == 2) ? 48'd255 : 48'($urandom_range(1, 20)));
      for (int i = 0; i < 320; i++) pending_words.push_back(random_word());
      if (ph == 0) begin
        // Keep the request up until the receiver has started its long stall.
        recv_hold = 1;
        wait (hold_cycles > 0);
        recv_hold = 0;
      end
      drain();
    end

    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
